// ===== rtl/dmacw_pkg.sv =====
// Package for the DMA chain length walker: widths, constants, stop codes
// and the walker state and result records. Depends on nothing.
`default_nettype none

package dmacw_pkg;

  localparam int ADDR_W  = 21;
  localparam int PTR_W   = 24;
  localparam int TOTAL_W = 32;
  localparam int CNT_W   = 21;

  localparam logic [PTR_W-1:0] END_MARK    = 24'hffffff;
  localparam logic [PTR_W-1:0] ADDR_MASK   = 24'h1ffffc;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 21'd2000000;
  localparam logic [CNT_W-1:0] CNT_MAX     = 21'h1fffff;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  typedef enum logic [1:0] {
    STOP_END   = 2'd0,
    STOP_LOOP  = 2'd1,
    STOP_LIMIT = 2'd2
  } stop_t;

  typedef struct packed {
    logic               busy;
    logic [ADDR_W-1:0]  current_address;
    logic [TOTAL_W-1:0] total_words;
    logic [CNT_W-1:0]   node_count;
    logic [PTR_W-1:0]   previous_address;
    logic [PTR_W-1:0]   lower_seen_address;
    logic [PTR_W-1:0]   upper_seen_address;
  } walk_state_t;

  typedef struct packed {
    logic               done_res;
    logic [ADDR_W-1:0]  fetch_address;
    logic [TOTAL_W-1:0] chain_size;
    stop_t              stop_reason;
  } walk_res_t;

endpackage

`default_nettype wire

// ===== rtl/dmacw_step.sv =====
// Next-state and result logic for one walker request.
// Depends on dmacw_pkg for the state and result records.
`default_nettype none

module dmacw_step (
  input  wire logic                             kind,
  input  wire logic [dmacw_pkg::PTR_W-1:0]      start_address,
  input  wire logic [dmacw_pkg::TOTAL_W-1:0]    header_word,
  input  wire logic [dmacw_pkg::CNT_W-1:0]      node_limit,
  input  wire dmacw_pkg::walk_state_t           state,
  output dmacw_pkg::walk_state_t                state_next,
  output logic                                  has_res,
  output dmacw_pkg::walk_res_t                  res
);

  dmacw_pkg::walk_state_t          base;
  logic                            visit;
  logic [dmacw_pkg::PTR_W-1:0]     vaddr;
  logic [dmacw_pkg::PTR_W-1:0]     masked;
  logic [dmacw_pkg::ADDR_W-1:0]    addr;
  logic                            over;

  always_comb begin
    base    = state;
    res     = '0;
    has_res = 1'b0;
    visit   = 1'b0;
    vaddr   = header_word[dmacw_pkg::PTR_W-1:0];
    if (kind == dmacw_pkg::KIND_START) begin
      base.busy               = 1'b1;
      base.total_words        = 32'd1;
      base.node_count         = '0;
      base.previous_address   = dmacw_pkg::END_MARK;
      base.lower_seen_address = dmacw_pkg::END_MARK;
      base.upper_seen_address = dmacw_pkg::END_MARK;
      vaddr                   = start_address;
      visit                   = 1'b1;
    end else if (state.busy) begin
      base.total_words = state.total_words + 32'(header_word[31:24]) + 32'd1;
      if (header_word[dmacw_pkg::PTR_W-1:0] == dmacw_pkg::END_MARK) begin
        base.busy       = 1'b0;
        has_res         = 1'b1;
        res.done_res    = 1'b1;
        res.chain_size  = base.total_words;
        res.stop_reason = dmacw_pkg::STOP_END;
      end else begin
        visit = 1'b1;
      end
    end

    state_next = base;
    masked     = vaddr & dmacw_pkg::ADDR_MASK;
    addr       = masked[dmacw_pkg::ADDR_W-1:0];
    over       = base.node_count > node_limit;
    if (visit) begin
      has_res                    = 1'b1;
      state_next.current_address = addr;
      if (base.node_count != dmacw_pkg::CNT_MAX) begin
        state_next.node_count = base.node_count + 21'd1;
      end
      if (over) begin
        state_next.busy = 1'b0;
        res.done_res    = 1'b1;
        res.chain_size  = base.total_words;
        res.stop_reason = dmacw_pkg::STOP_LIMIT;
      end else if (masked == base.lower_seen_address || masked == base.upper_seen_address) begin
        state_next.busy = 1'b0;
        res.done_res    = 1'b1;
        res.chain_size  = base.total_words;
        res.stop_reason = dmacw_pkg::STOP_LOOP;
      end else begin
        if (masked < base.previous_address) begin
          state_next.lower_seen_address = masked;
        end else begin
          state_next.upper_seen_address = masked;
        end
        state_next.previous_address = masked;
        res.fetch_address           = addr;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dma_chain_length_walker_unit.sv =====
// Top level of the DMA chain length walker: input register, walker state,
// result register and configuration register. Depends on dmacw_pkg and dmacw_step.
`default_nettype none

// The walker takes one request in every clock cycle while in_stall is low;
// in_stall holds a request with a result while the output is stalled. A
// request passes the input register, then the step logic writes the result
// register and updates the walker state in the same cycle, so a header may follow
// its fetch request directly. A header arriving while no walk runs produces no
// result. The node limit is written through the cfg channel, which is always
// ready, and must only be written while the walker is idle.
module dma_chain_length_walker_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             kind,
  input  wire logic [dmacw_pkg::PTR_W-1:0]      start_address,
  input  wire logic [dmacw_pkg::TOTAL_W-1:0]    header_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  done_res,
  output logic [dmacw_pkg::ADDR_W-1:0]          fetch_address,
  output logic [dmacw_pkg::TOTAL_W-1:0]         chain_size,
  output logic [1:0]                            stop_reason,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dmacw_pkg::CNT_W-1:0]      cfg_data
);

  logic                             s1_valid;
  logic                             s1_kind;
  logic [dmacw_pkg::PTR_W-1:0]      s1_start;
  logic [dmacw_pkg::TOTAL_W-1:0]    s1_header;
  logic [dmacw_pkg::CNT_W-1:0]      node_limit;
  dmacw_pkg::walk_state_t           state;
  dmacw_pkg::walk_state_t           state_next;
  logic                             has_res;
  dmacw_pkg::walk_res_t             res;
  dmacw_pkg::walk_res_t             out_res;
  logic                             out_free;
  logic                             s1_go;

  dmacw_step u_step (
    .kind          (s1_kind),
    .start_address (s1_start),
    .header_word   (s1_header),
    .node_limit    (node_limit),
    .state         (state),
    .state_next    (state_next),
    .has_res       (has_res),
    .res           (res)
  );

  assign out_free  = !out_valid || !out_stall;
  assign s1_go     = s1_valid && (!has_res || out_free);
  assign in_stall  = s1_valid && !s1_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind   <= kind;
      s1_start  <= start_address;
      s1_header <= header_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.busy               <= 1'b0;
      state.current_address    <= '0;
      state.total_words        <= '0;
      state.node_count         <= '0;
      state.previous_address   <= dmacw_pkg::END_MARK;
      state.lower_seen_address <= dmacw_pkg::END_MARK;
      state.upper_seen_address <= dmacw_pkg::END_MARK;
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= dmacw_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_res) begin
      out_res <= res;
    end
  end

  assign done_res      = out_res.done_res;
  assign fetch_address = out_res.fetch_address;
  assign chain_size    = out_res.chain_size;
  assign stop_reason   = out_res.stop_reason;

`ifndef SYNTHESIS
  a_done_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> fetch_address == '0)
    else $error("finished result carries a fetch address");

  a_fetch_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> chain_size == '0 && stop_reason == dmacw_pkg::STOP_END)
    else $error("fetch request carries a total or stop reason");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    s1_go && has_res && res.done_res |=> !state.busy)
    else $error("walker still busy after a finished result");

  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    s1_go && has_res && !res.done_res |=> state.busy)
    else $error("walker idle after a fetch request");
`endif

endmodule

`default_nettype wire
